// ===== rtl/fltw_pkg.sv =====
package fltw_pkg;

    localparam int unsigned PA_W   = 36;
    localparam int unsigned LA_W   = 48;
    localparam int unsigned PTE_W  = 64;
    localparam int unsigned LVL_W  = 3;
    localparam int unsigned SIZE_W = 2;
    localparam int unsigned IDX_W  = 9;

    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 112;

    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_READ_RSP  = 1'b1;

    localparam logic KIND_READ_REQ = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_FAULT = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_4K    = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_2M    = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_1G    = 2'd3;

    localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
    localparam logic [LVL_W-1:0] LVL_1    = 3'd1;
    localparam logic [LVL_W-1:0] LVL_2    = 3'd2;
    localparam logic [LVL_W-1:0] LVL_3    = 3'd3;
    localparam logic [LVL_W-1:0] LVL_4    = 3'd4;

    localparam logic [PA_W-1:0] FRAME_MASK = 36'h7_FFFF_F000;
    localparam logic [PA_W-1:0] MASK_1G    = 36'hF_C000_0000;
    localparam logic [PA_W-1:0] MASK_2M    = 36'hF_FFE0_0000;
    localparam logic [PA_W-1:0] OFF_1G     = 36'h0_3FFF_FFFF;
    localparam logic [PA_W-1:0] OFF_2M     = 36'h0_001F_FFFF;
    localparam logic [PA_W-1:0] OFF_4K     = 36'h0_0000_0FFF;
    localparam int unsigned     LARGE_BIT  = 7;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LA_W-1:0]  addr;
        logic [PA_W-1:0]  last_entry;
    } t_walk_state;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [PA_W-1:0]   mem_addr;
        logic [PA_W-1:0]   xlat_addr;
        logic [SIZE_W-1:0] page_size;
        logic [PA_W-1:0]   entry_addr;
    } t_walk_result;

    function automatic logic [PA_W-1:0] entry_at(
        input logic [PA_W-1:0]  table_base,
        input logic [LA_W-1:0]  lin,
        input logic [LVL_W-1:0] level
    );
        logic [IDX_W-1:0] idx;
        begin
            case (level)
                LVL_4:   idx = lin[47:39];
                LVL_3:   idx = lin[38:30];
                LVL_2:   idx = lin[29:21];
                default: idx = lin[20:12];
            endcase
            entry_at = (table_base & FRAME_MASK) | {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
        end
    endfunction

endpackage

// ===== rtl/fltw_step.sv =====
module fltw_step
    import fltw_pkg::*;
(
    input  t_walk_state          i_state,
    input  logic [PA_W-1:0]      i_root,
    input  logic                 i_action,
    input  logic [LA_W-1:0]      i_lin_addr,
    input  logic [PTE_W-1:0]     i_read_data,
    output t_walk_state          o_state,
    output t_walk_result         o_result
);

    logic [PA_W-1:0] w_pte;
    logic            w_large;

    assign w_pte   = i_read_data[PA_W-1:0];
    assign w_large = i_read_data[LARGE_BIT];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_action == ACT_TRANSLATE) begin
            if (i_state.level == LVL_IDLE) begin
                o_state.addr        = i_lin_addr;
                o_state.level       = LVL_4;
                o_state.last_entry  = entry_at(i_root, i_lin_addr, LVL_4);
                o_result.valid      = 1'b1;
                o_result.kind       = KIND_READ_REQ;
                o_result.mem_addr   = o_state.last_entry;
            end
        end else begin
            unique case (i_state.level)
                LVL_4, LVL_3, LVL_2: begin
                    if (w_large) begin
                        o_state.level       = LVL_IDLE;
                        o_result.valid      = 1'b1;
                        o_result.kind       = KIND_DONE;
                        if (i_state.level == LVL_3) begin
                            o_result.xlat_addr  = (w_pte & MASK_1G)
                                                | (i_state.addr[PA_W-1:0] & OFF_1G);
                            o_result.page_size  = SIZE_1G;
                            o_result.entry_addr = i_state.last_entry;
                        end else if (i_state.level == LVL_2) begin
                            o_result.xlat_addr  = (w_pte & MASK_2M)
                                                | (i_state.addr[PA_W-1:0] & OFF_2M);
                            o_result.page_size  = SIZE_2M;
                            o_result.entry_addr = i_state.last_entry;
                        end
                    end else begin
                        o_state.level      = i_state.level - LVL_1;
                        o_state.last_entry = entry_at(w_pte, i_state.addr, o_state.level);
                        o_result.valid     = 1'b1;
                        o_result.kind      = KIND_READ_REQ;
                        o_result.mem_addr  = o_state.last_entry;
                    end
                end
                LVL_1: begin
                    o_state.level       = LVL_IDLE;
                    o_result.valid      = 1'b1;
                    o_result.kind       = KIND_DONE;
                    o_result.xlat_addr  = (w_pte & FRAME_MASK)
                                        | (i_state.addr[PA_W-1:0] & OFF_4K);
                    o_result.page_size  = SIZE_4K;
                    o_result.entry_addr = i_state.last_entry;
                end
                default: begin
                    o_state.level = LVL_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// Four-level page-table walker for 4K, 2M and 1G pages. A translate request
// (tuser 0) produces a read request for the top-level entry; every memory
// read response (tuser 1) produces either the read request for the next level
// or a finished translation (tuser 1 on the output). Requests that arrive
// during a walk and responses that arrive while idle are dropped. One request
// is taken every cycle while the output register can take a result; a result
// passes the input register, then the single level-step logic, then the result
// register. The root table base is used when a translate request leaves the
// input register, so it should be written only while no request is in flight.
module four_level_page_table_walker
    import fltw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PA_W-1:0]       i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: lin_addr[47:0], read_data[111:48]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: action
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: mem_addr[35:0], xlat_addr[71:36], page_size[73:72],
    // entry_addr[109:74], zero fill[111:110]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // tuser: kind
    output logic                  o_m_tuser
);

    logic                 r_in_valid;
    logic                 r_in_action;
    logic [LA_W-1:0]      r_in_lin;
    logic [PTE_W-1:0]     r_in_pte;
    logic [PA_W-1:0]      r_root;
    t_walk_state          r_state;
    t_walk_result         r_out;

    t_walk_state          n_state;
    t_walk_result         w_res;
    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_load;

    assign w_out_free = !r_out.valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign w_load     = w_advance && w_res.valid;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready = 1'b1;

    fltw_step u_step (
        .i_state       (r_state),
        .i_root        (r_root),
        .i_action      (r_in_action),
        .i_lin_addr    (r_in_lin),
        .i_read_data   (r_in_pte),
        .o_state       (n_state),
        .o_result      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out.valid <= 1'b0;
            r_state    <= '0;
            r_root     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_root <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_out_free) begin
                r_out.valid <= w_load;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_action <= i_s_tuser;
            r_in_lin    <= i_s_tdata[LA_W-1:0];
            r_in_pte    <= i_s_tdata[LA_W+PTE_W-1:LA_W];
        end
        if (w_load) begin
            r_out.kind       <= w_res.kind;
            r_out.mem_addr   <= w_res.mem_addr;
            r_out.xlat_addr  <= w_res.xlat_addr;
            r_out.page_size  <= w_res.page_size;
            r_out.entry_addr <= w_res.entry_addr;
        end
    end

    assign o_m_tvalid = r_out.valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {2'b00, r_out.entry_addr, r_out.page_size,
                         r_out.xlat_addr, r_out.mem_addr};

`ifndef ASSERT_OFF
    a_read_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && r_out.kind == KIND_READ_REQ) |->
        (r_out.xlat_addr == '0 && r_out.page_size == SIZE_FAULT && r_out.entry_addr == '0))
        else $error("read request carries translation fields");

    a_fault_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && r_out.kind == KIND_DONE && r_out.page_size == SIZE_FAULT) |->
        (r_out.xlat_addr == '0 && r_out.entry_addr == '0 && r_out.mem_addr == '0))
        else $error("fault result carries addresses");

    a_read_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.kind == KIND_READ_REQ) |=> (r_state.level != LVL_IDLE))
        else $error("walker idle after issuing a read request");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.kind == KIND_DONE) |=> (r_state.level == LVL_IDLE))
        else $error("walker busy after finishing a translation");
`endif

endmodule
